// ===== design/sliding_window_maximum_assert.svh =====
`ifndef SLIDING_WINDOW_MAXIMUM_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/swm_pkg.sv =====
package swm_pkg;

  localparam int unsigned MAX_WINDOW = 64;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned WS_W       = 7;
  // arrival position, wraps at a power of two of at least 2*MAX_WINDOW
  localparam int unsigned POS_W      = $clog2(2 * MAX_WINDOW);
  localparam int unsigned CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CMP_W      = (POS_W > WS_W) ? POS_W : WS_W;

  localparam logic [WS_W-1:0] WS_RESET = WS_W'(1);

  // register byte addresses
  localparam logic [2:0] ADDR_WINDOW_SIZE = 3'd0;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
  } entry_t;

  typedef struct packed {
    logic                     shift;   // drop the head, move every entry one cell forward
    logic                     insert;  // place the new word behind the surviving candidates
    logic                     clear;   // end of array
    logic signed [DATA_W-1:0] sample;
    logic [POS_W-1:0]         pos;
  } ctrl_t;

endpackage

// ===== design/swm_cell.sv =====
module swm_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  swm_pkg::ctrl_t ctrl_i,
  input  swm_pkg::entry_t next_i,       // neighbor toward the tail
  input  logic           prev_kept_i,   // neighbor toward the head survives
  output swm_pkg::entry_t entry_o,
  output logic           kept_o
);

  logic                             valid_q, valid_d;
  logic signed [swm_pkg::DATA_W-1:0] value_q, value_d;
  logic [swm_pkg::POS_W-1:0]        pos_q, pos_d;
  swm_pkg::entry_t                  own;
  swm_pkg::entry_t                  view;

  assign own     = '{valid: valid_q, value: value_q, pos: pos_q};
  assign entry_o = own;

  // contents as seen after an optional one-cell advance
  assign view   = ctrl_i.shift ? next_i : own;
  assign kept_o = view.valid && (view.value > ctrl_i.sample);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    pos_d   = pos_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.insert) begin
      if (kept_o) begin
        valid_d = 1'b1;
        value_d = view.value;
        pos_d   = view.pos;
      end else if (prev_kept_i) begin
        valid_d = 1'b1;
        value_d = ctrl_i.sample;
        pos_d   = ctrl_i.pos;
      end else begin
        valid_d = 1'b0;
      end
    end else if (ctrl_i.shift) begin
      valid_d = view.valid;
      value_d = view.value;
      pos_d   = view.pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
  end

endmodule

// ===== design/sliding_window_maximum.sv =====
// Running maximum over the last window_size signed 32-bit words of an array.
// Candidates live in a row of MAX_WINDOW cells, head at cell 0, values strictly
// falling toward the tail; every cell compares itself with the new word at
// once, so a word whose array holds window_size words or more yields its
// window maximum in the same cycle it is taken, landing in an output register.
// Throughput is one word per clock while the result stream is not held. When
// window_size was lowered since the last word, each head candidate beyond the
// first that has fallen out of the window holds the word back while the row
// advances one cell per clock to drop it. Words of an array shorter than the
// window give no result; tlast ends the array, marks its final result and
// empties the row. window_size 0 acts as 1, values above 64 act as 64. Write
// window_size only while the block is idle. No clearing pass is needed after
// reset.
`include "sliding_window_maximum_assert.svh"

module sliding_window_maximum (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] sample
  input  logic        s_axis_tlast_i,   // last_sample
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] window_max
  output logic        m_axis_tlast_o,   // last_result
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned N = swm_pkg::MAX_WINDOW;

  // ---------------------------------------------------------------- registers
  logic [swm_pkg::WS_W-1:0]  ws_q, ws_d;
  logic [swm_pkg::CMP_W-1:0] w_eff;

  assign pready = 1'b1;

  always_comb begin
    ws_d = ws_q;
    if (psel && penable && pwrite && (paddr[2] == swm_pkg::ADDR_WINDOW_SIZE[2])) begin
      ws_d = pwdata[swm_pkg::WS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == swm_pkg::ADDR_WINDOW_SIZE[2]) ? 32'(ws_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= swm_pkg::WS_RESET;
    end else begin
      ws_q <= ws_d;
    end
  end

  // clamp into 1..MAX_WINDOW
  always_comb begin
    w_eff = swm_pkg::CMP_W'(ws_q);
    if (ws_q == '0) begin
      w_eff = swm_pkg::CMP_W'(1);
    end else if (swm_pkg::CMP_W'(ws_q) > swm_pkg::CMP_W'(N)) begin
      w_eff = swm_pkg::CMP_W'(N);
    end
  end

  // ---------------------------------------------------------------- cell row
  swm_pkg::entry_t entries [0:N];   // entry N is a permanent empty slot
  logic            kept    [0:N-1];
  swm_pkg::ctrl_t  ctrl;

  assign entries[N] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic prev_kept;
    if (i == 0) begin : g_head
      assign prev_kept = 1'b1;
    end else begin : g_body
      assign prev_kept = kept[i-1];
    end
    swm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .next_i      (entries[i+1]),
      .prev_kept_i (prev_kept),
      .entry_o     (entries[i]),
      .kept_o      (kept[i])
    );
  end

  // ---------------------------------------------------------------- control
  logic [swm_pkg::POS_W-1:0] pos_q, pos_d;
  logic [swm_pkg::CNT_W-1:0] fill_q, fill_d;
  logic [swm_pkg::POS_W-1:0] age0, age1;
  logic                      expired0, expired1;
  logic                      out_free, stall, s_acc, produce;
  logic signed [31:0]        sample;
  logic signed [31:0]        head_value;
  logic                      m_valid_q, m_valid_d;
  logic [31:0]               m_data_q, m_data_d;
  logic                      m_last_q, m_last_d;

  assign sample = s_axis_tdata_i;

  // ages wrap with the position counter
  assign age0     = pos_q - entries[0].pos;
  assign age1     = pos_q - entries[1].pos;
  assign expired0 = entries[0].valid && (swm_pkg::CMP_W'(age0) >= w_eff);
  assign expired1 = entries[1].valid && (swm_pkg::CMP_W'(age1) >= w_eff);

  assign out_free        = !m_valid_q || m_axis_tready_i;
  // two expired candidates at the head: advance the row and hold the word
  assign stall           = expired0 && expired1;
  assign s_axis_tready_o = out_free && !stall;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  assign ctrl.shift  = s_axis_tvalid_i && out_free && expired0;
  assign ctrl.insert = s_acc;
  assign ctrl.clear  = s_acc && s_axis_tlast_i;
  assign ctrl.sample = sample;
  assign ctrl.pos    = pos_q;

  // the head survivor beats the new word, otherwise the new word is the head
  assign head_value = kept[0] ? (expired0 ? entries[1].value : entries[0].value) : sample;

  always_comb begin
    fill_d = fill_q;
    pos_d  = pos_q;
    if (s_acc) begin
      if (s_axis_tlast_i) begin
        fill_d = '0;
        pos_d  = '0;
      end else begin
        pos_d = pos_q + swm_pkg::POS_W'(1);
        if (fill_q < swm_pkg::CNT_W'(N)) begin
          fill_d = fill_q + swm_pkg::CNT_W'(1);
        end
      end
    end
  end

  // result qualifies on the count including this word
  always_comb begin
    produce = 1'b0;
    if (fill_q < swm_pkg::CNT_W'(N)) begin
      produce = swm_pkg::CMP_W'(fill_q + swm_pkg::CNT_W'(1)) >= w_eff;
    end else begin
      produce = swm_pkg::CMP_W'(fill_q) >= w_eff;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    if (s_acc && produce) begin
      m_valid_d = 1'b1;
      m_data_d  = head_value;
      m_last_d  = s_axis_tlast_i;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      fill_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      fill_q    <= fill_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // ---------------------------------------------------------------- checks
  `SWM_ASSERT_IMP(a_head_order, entries[0].valid && entries[1].valid, $signed(entries[0].value) > $signed(entries[1].value), "candidate row not strictly falling at head")
  `SWM_ASSERT_IMP(a_row_packed, !entries[0].valid, !entries[1].valid, "candidate behind an empty head cell")
  `SWM_ASSERT_NXT(a_last_clears, s_acc && s_axis_tlast_i, !entries[0].valid && (pos_q == '0) && (fill_q == '0), "array state not cleared after last word")
  `SWM_ASSERT_NXT(a_result_loaded, s_acc && produce, m_axis_tvalid_o, "qualifying word left no result")

endmodule
